// ===== rtl/ranrot_pkg.sv =====
`default_nettype none

package ranrot_pkg;

  localparam int MAX_LAG_DEF = 64;

  localparam int WORD_W      = 32;
  localparam int LAG_LONG_W  = 7;
  localparam int LAG_SHORT_W = 6;
  localparam int SEED_IDX_W  = 6;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [LAG_LONG_W-1:0]  LAG_LONG_RST  = 7'd17;
  localparam logic [LAG_SHORT_W-1:0] LAG_SHORT_RST = 6'd9;

  localparam int ROT_A = 9;
  localparam int ROT_B = 13;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // register select is paddr[2]
  localparam logic REG_LAG_LONG  = 1'b0;
  localparam logic REG_LAG_SHORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RF_RD,
    ST_RF_WR,
    ST_RD_ISSUE,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic [LAG_LONG_W-1:0]  lag_long;
    logic [LAG_SHORT_W-1:0] lag_short;
  } cfg_t;

  typedef struct packed {
    logic seed_wr;
    logic rf_start;
    logic rf_rd;
    logic rf_wr;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic rf_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/ranrot_req_if.sv =====
`default_nettype none

interface ranrot_req_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [ranrot_pkg::SEED_IDX_W-1:0] seed_index;
  logic [ranrot_pkg::WORD_W-1:0]     seed_value;

  modport source (output valid, operation, seed_index, seed_value, input ready);
  modport sink   (input valid, operation, seed_index, seed_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/ranrot_rsp_if.sv =====
`default_nettype none

interface ranrot_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ranrot_pkg::WORD_W-1:0] random_word;

  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/ranrot_rotating_lagged_prng.sv =====
`default_nettype none

// RANROT pseudorandom word generator. Load every buffer word up to lag_long
// with seed transfers (operation 0) before the first request; each load
// restarts the read position. A request (operation 1) returns one 32-bit
// word: when unread words remain, through a buffer read and then the output
// register; when the read position has run out, only after an in-place refill
// of the buffer memory that spends one read and one write per word. A finished
// word waits in the output register while the next transfer is taken in.
// Buffer words never loaded since reset read as undefined. Lag registers are
// written at APB byte addresses 0 (lag_long) and 4 (lag_short) and take effect
// at the next refill.
module ranrot_rotating_lagged_prng #(
  parameter int MAX_LAG = ranrot_pkg::MAX_LAG_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ranrot_req_if.sink                             in_chan,
  ranrot_rsp_if.source                           out_chan,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ranrot_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ranrot_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ranrot_pkg::APB_DATA_W-1:0] prdata,
  output logic                                   pready
);

  ranrot_pkg::cfg_t  cfg;
  ranrot_pkg::cmd_t  cmd;
  ranrot_pkg::stat_t stat;

  ranrot_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ranrot_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  ranrot_dp #(
    .MAX_LAG (MAX_LAG)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .seed_index  (in_chan.seed_index),
    .seed_value  (in_chan.seed_value),
    .random_word (out_chan.random_word)
  );

endmodule

`default_nettype wire

// ===== rtl/ranrot_cfg.sv =====
`default_nettype none

module ranrot_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ranrot_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ranrot_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ranrot_pkg::APB_DATA_W-1:0] prdata,
  output logic                                   pready,
  output ranrot_pkg::cfg_t                       cfg_o
);

  logic [ranrot_pkg::LAG_LONG_W-1:0]  lag_long_r;
  logic [ranrot_pkg::LAG_SHORT_W-1:0] lag_short_r;
  logic                               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_long_r  <= ranrot_pkg::LAG_LONG_RST;
      lag_short_r <= ranrot_pkg::LAG_SHORT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        ranrot_pkg::REG_LAG_LONG:  lag_long_r  <= pwdata[ranrot_pkg::LAG_LONG_W-1:0];
        ranrot_pkg::REG_LAG_SHORT: lag_short_r <= pwdata[ranrot_pkg::LAG_SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ranrot_pkg::REG_LAG_LONG:  prdata = ranrot_pkg::APB_DATA_W'(lag_long_r);
      ranrot_pkg::REG_LAG_SHORT: prdata = ranrot_pkg::APB_DATA_W'(lag_short_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.lag_long  = lag_long_r;
  assign cfg_o.lag_short = lag_short_r;

endmodule

`default_nettype wire

// ===== rtl/ranrot_ctrl.sv =====
`default_nettype none

module ranrot_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_operation,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ranrot_pkg::stat_t stat_i,
  output ranrot_pkg::cmd_t       cmd_o
);

  ranrot_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ranrot_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = (state_r == ranrot_pkg::ST_IDLE);
    accept    = in_valid && in_ready;
    case (state_r)
      ranrot_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == ranrot_pkg::OP_LOAD) begin
            cmd_o.seed_wr = 1'b1;
          end else if (stat_i.pos_zero) begin
            cmd_o.rf_start = 1'b1;
            state_nxt      = ranrot_pkg::ST_RF_RD;
          end else begin
            cmd_o.rd_issue = 1'b1;
            state_nxt      = ranrot_pkg::ST_DELIVER;
          end
        end
      end
      ranrot_pkg::ST_RF_RD: begin
        cmd_o.rf_rd = 1'b1;
        state_nxt   = ranrot_pkg::ST_RF_WR;
      end
      ranrot_pkg::ST_RF_WR: begin
        cmd_o.rf_wr = 1'b1;
        state_nxt   = stat_i.rf_last ? ranrot_pkg::ST_RD_ISSUE : ranrot_pkg::ST_RF_RD;
      end
      ranrot_pkg::ST_RD_ISSUE: begin
        cmd_o.rd_issue = 1'b1;
        state_nxt      = ranrot_pkg::ST_DELIVER;
      end
      ranrot_pkg::ST_DELIVER: begin
        // hold the word until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ranrot_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ranrot_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd_o.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  a_rf_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.rf_rd |=> cmd_o.rf_wr)
    else $error("refill read not followed by its write");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_refill_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == ranrot_pkg::OP_REQUEST && stat_i.pos_zero)
      |=> state_r == ranrot_pkg::ST_RF_RD)
    else $error("request at empty position did not start a refill");

endmodule

`default_nettype wire

// ===== rtl/ranrot_dp.sv =====
`default_nettype none

module ranrot_dp #(
  parameter int MAX_LAG = ranrot_pkg::MAX_LAG_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ranrot_pkg::cfg_t                  cfg_i,
  input  wire ranrot_pkg::cmd_t                  cmd_i,
  output ranrot_pkg::stat_t                      stat_o,
  input  wire logic [ranrot_pkg::SEED_IDX_W-1:0] seed_index,
  input  wire logic [ranrot_pkg::WORD_W-1:0]     seed_value,
  output logic      [ranrot_pkg::WORD_W-1:0]     random_word
);

  localparam int AW  = $clog2(MAX_LAG);
  localparam int PW  = $clog2(MAX_LAG + 1);
  localparam int BW0 = (PW > ranrot_pkg::LAG_LONG_W) ? PW : ranrot_pkg::LAG_LONG_W;
  localparam int XW  = BW0 + 1;
  localparam int W   = ranrot_pkg::WORD_W;

  logic [W-1:0]  mem [MAX_LAG];
  logic [W-1:0]  rd_a_r, rd_b_r, out_word_r;
  logic [PW-1:0] pos_r, idx_r;
  logic [XW-1:0] ll_x, ls_x, sidx_x;
  logic [PW-1:0] eff_long, eff_short, pos_dec, j_pos;
  logic [AW-1:0] addr_a, addr_b;
  logic          seed_ok;
  logic [W-1:0]  rf_sum;

  // saturate the lags to their legal ranges
  always_comb begin
    ll_x = XW'(cfg_i.lag_long);
    if (ll_x < XW'(2)) begin
      ll_x = XW'(2);
    end else if (ll_x > XW'(MAX_LAG)) begin
      ll_x = XW'(MAX_LAG);
    end
    ls_x = XW'(cfg_i.lag_short);
    if (ls_x < XW'(1)) begin
      ls_x = XW'(1);
    end else if (ls_x > ll_x - XW'(1)) begin
      ls_x = ll_x - XW'(1);
    end
    eff_long  = PW'(ll_x);
    eff_short = PW'(ls_x);
  end

  assign sidx_x  = XW'(seed_index);
  assign seed_ok = sidx_x < XW'(MAX_LAG);
  assign pos_dec = pos_r - PW'(1);
  // low words pair with the untouched upper words, the rest with refreshed ones
  assign j_pos   = (idx_r < eff_short) ? idx_r + (eff_long - eff_short) : idx_r - eff_short;
  assign addr_a  = cmd_i.rd_issue ? pos_dec[AW-1:0] : idx_r[AW-1:0];
  assign addr_b  = j_pos[AW-1:0];

  assign rf_sum = ((rd_a_r << ranrot_pkg::ROT_A) | (rd_a_r >> (W - ranrot_pkg::ROT_A)))
                + ((rd_b_r << ranrot_pkg::ROT_B) | (rd_b_r >> (W - ranrot_pkg::ROT_B)));

  always_ff @(posedge clk) begin
    if (cmd_i.seed_wr && seed_ok) begin
      mem[sidx_x[AW-1:0]] <= seed_value;
    end else if (cmd_i.rf_wr) begin
      mem[idx_r[AW-1:0]] <= rf_sum;
    end
    if (cmd_i.rf_rd || cmd_i.rd_issue) begin
      rd_a_r <= mem[addr_a];
    end
    if (cmd_i.rf_rd) begin
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd_i.seed_wr) begin
      pos_r <= '0;
    end else if (cmd_i.rf_wr && stat_o.rf_last) begin
      pos_r <= eff_long;
    end else if (cmd_i.rd_issue) begin
      pos_r <= pos_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rf_start) begin
      idx_r <= '0;
    end else if (cmd_i.rf_wr) begin
      idx_r <= idx_r + PW'(1);
    end
    if (cmd_i.out_load) begin
      out_word_r <= rd_a_r;
    end
  end

  assign stat_o.pos_zero = (pos_r == '0);
  assign stat_o.rf_last  = (idx_r == eff_long - PW'(1));
  assign random_word     = out_word_r;

  a_pos_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.rf_wr && stat_o.rf_last) |=> pos_r == $past(eff_long))
    else $error("read position not set to long lag after refill");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_LAG))
    else $error("read position beyond buffer");

endmodule

`default_nettype wire
